[design/gipm_pkg.sv]
// Shared constants, types and the arctangent table of the ground-to-image map.
// Used by every module under design/.
`default_nettype none
package gipm_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int ANGLE_GUARD = 4;
   localparam int ANG_FRAC    = 30;
   localparam int ANG_SH      = ANG_FRAC - FRAC_BITS - ANGLE_GUARD;
   localparam int OUT_SH      = FRAC_BITS + ANGLE_GUARD;

   localparam int CW     = 56;
   localparam int AW     = 34;
   localparam int SW     = 7;
   localparam int MSB_W  = 6;
   localparam int STEPS  = 30;
   localparam int NORM_MSB = 50;
   localparam int XR_SHIFT = 20;

   localparam int DIFF_W  = 33;
   localparam int FRAC_W  = 20;
   localparam int REF_W   = 21;
   localparam int NUM_W   = 26;
   localparam int RECIP_W = 31;
   localparam int PROD_W  = NUM_W + RECIP_W;
   localparam int HGT_W   = 31;
   localparam int GAIN_W  = 31;
   localparam int HPROD_W = HGT_W + GAIN_W;
   localparam int HPROD_SH = 10;

   localparam int NORM_LAT = 2;
   localparam int FRAC_LAT = 3;
   localparam int LATENCY  = 1 + NORM_LAT + STEPS + 1 + NORM_LAT + STEPS + FRAC_LAT;

   localparam logic [GAIN_W-1:0]   GAIN_Q30    = 31'd1768195363;
   localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [FRAC_W-1:0] FRAC_MAX = 20'sd524287;
   localparam logic [37:0] FRAC_MAX_MAG = 38'd524287;
   localparam logic [37:0] FRAC_MIN_MAG = 38'd524288;

   localparam logic signed [AW-1:0] ATAN_TABLE [STEPS] = '{
      34'sh03243F6A8 >> 0, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
      34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
      34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
      34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
      34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
      34'sh0000001F, 34'sh0000000F, 34'sh00000008, 34'sh00000004, 34'sh00000002
   };

   typedef enum logic [2:0] {
      REG_HEIGHT  = 3'd0,
      REG_FORWARD = 3'd1,
      REG_LATERAL = 3'd2,
      REG_PITCH   = 3'd3,
      REG_YAW     = 3'd4,
      REG_HALF_AP = 3'd5,
      REG_RECIP   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                  valid;
      logic                  neg;
      logic                  degen;
      logic signed [SW-1:0]  shift;
      logic signed [AW-1:0]  az;
   } side_type;

endpackage
`default_nettype wire

[design/gipm_norm.sv]
// Two-stage pair normalizer: leading-one search, then shift to the CORDIC range
// and quarter turn of left-half vectors. Depends on gipm_pkg.
`default_nettype none
module gipm_norm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [gipm_pkg::CW-1:0] in_x,
   input  logic signed [gipm_pkg::CW-1:0] in_y,
   input  gipm_pkg::side_type            in_side,
   output logic signed [gipm_pkg::CW-1:0] out_x,
   output logic signed [gipm_pkg::CW-1:0] out_y,
   output logic signed [gipm_pkg::AW-1:0] out_z,
   output gipm_pkg::side_type            out_side
);
   import gipm_pkg::*;

   logic [CW-1:0]        mag_x;
   logic [CW-1:0]        mag_y;
   logic [CW-1:0]        mag_or;
   logic [MSB_W-1:0]     msb_in;
   logic signed [CW-1:0] xa_ff, ya_ff;
   logic [MSB_W-1:0]     msb_ff;
   logic                 nz_ff;
   side_type             side_a_ff;

   logic [MSB_W-1:0]     amt;
   logic [SW-1:0]        shift_val;
   logic signed [CW-1:0] sx, sy;
   logic signed [CW-1:0] x_in, y_in;
   logic signed [AW-1:0] z_in;
   side_type             side_in;
   logic signed [CW-1:0] x_ff, y_ff;
   logic signed [AW-1:0] z_ff;
   side_type             side_ff;

   always_comb begin
      mag_x  = in_x[CW-1] ? CW'(-in_x) : CW'(in_x);
      mag_y  = in_y[CW-1] ? CW'(-in_y) : CW'(in_y);
      mag_or = mag_x | mag_y;
      msb_in = '0;
      for (int k = 0; k < CW; k++) begin
         if (mag_or[k]) msb_in = MSB_W'(k);
      end
   end

   always_ff @(posedge clock) begin
      xa_ff  <= in_x;
      ya_ff  <= in_y;
      msb_ff <= msb_in;
      nz_ff  <= |mag_or;
      if (reset) begin
         side_a_ff <= '0;
      end else begin
         side_a_ff <= in_side;
      end
   end

   always_comb begin
      shift_val = SW'(NORM_MSB) - {1'b0, msb_ff};
      if (!nz_ff) begin
         amt       = '0;
         sx        = xa_ff;
         sy        = ya_ff;
         shift_val = '0;
      end else if (msb_ff > MSB_W'(NORM_MSB)) begin
         amt = msb_ff - MSB_W'(NORM_MSB);
         sx  = xa_ff >>> amt;
         sy  = ya_ff >>> amt;
      end else begin
         amt = MSB_W'(NORM_MSB) - msb_ff;
         sx  = xa_ff <<< amt;
         sy  = ya_ff <<< amt;
      end
      if (sx[CW-1]) begin
         if (!sy[CW-1]) begin
            x_in = sy;
            y_in = -sx;
            z_in = HALF_PI_Q30;
         end else begin
            x_in = -sy;
            y_in = sx;
            z_in = -HALF_PI_Q30;
         end
      end else begin
         x_in = sx;
         y_in = sy;
         z_in = '0;
      end
      side_in       = side_a_ff;
      side_in.shift = shift_val;
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_in;
      end
   end

   assign out_x    = x_ff;
   assign out_y    = y_ff;
   assign out_z    = z_ff;
   assign out_side = side_ff;

endmodule
`default_nettype wire

[design/gipm_cordic.sv]
// Vectoring CORDIC, one micro-rotation per register stage, sideband carried along.
// Depends on gipm_pkg for widths and the arctangent table.
`default_nettype none
module gipm_cordic (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [gipm_pkg::CW-1:0] in_x,
   input  logic signed [gipm_pkg::CW-1:0] in_y,
   input  logic signed [gipm_pkg::AW-1:0] in_z,
   input  gipm_pkg::side_type            in_side,
   output logic signed [gipm_pkg::CW-1:0] out_x,
   output logic signed [gipm_pkg::AW-1:0] out_z,
   output gipm_pkg::side_type            out_side
);
   import gipm_pkg::*;

   logic signed [CW-1:0] x_st [STEPS+1];
   logic signed [CW-1:0] y_st [STEPS+1];
   logic signed [AW-1:0] z_st [STEPS+1];
   side_type             s_st [STEPS+1];

   assign x_st[0] = in_x;
   assign y_st[0] = in_y;
   assign z_st[0] = in_z;
   assign s_st[0] = in_side;

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [CW-1:0] x_in, y_in, x_ff, y_ff;
      logic signed [AW-1:0] z_in, z_ff;
      side_type             side_ff;

      always_comb begin
         if (!y_st[i][CW-1]) begin
            x_in = x_st[i] + (y_st[i] >>> i);
            y_in = y_st[i] - (x_st[i] >>> i);
            z_in = z_st[i] + ATAN_TABLE[i];
         end else begin
            x_in = x_st[i] - (y_st[i] >>> i);
            y_in = y_st[i] + (x_st[i] >>> i);
            z_in = z_st[i] - ATAN_TABLE[i];
         end
      end

      always_ff @(posedge clock) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         if (reset) begin
            side_ff <= '0;
         end else begin
            side_ff <= s_st[i];
         end
      end

      assign x_st[i+1] = x_ff;
      assign y_st[i+1] = y_ff;
      assign z_st[i+1] = z_ff;
      assign s_st[i+1] = side_ff;
   end

   assign out_x    = x_st[STEPS];
   assign out_z    = z_st[STEPS];
   assign out_side = s_st[STEPS];

endmodule
`default_nettype wire

[design/gipm_frac.sv]
// Three-stage angle-to-fraction unit: round and offset, scale, round and clip.
// Depends on gipm_pkg.
`default_nettype none
module gipm_frac (
   input  logic                                clock,
   input  logic signed [gipm_pkg::AW-1:0]      ang,
   input  logic signed [gipm_pkg::REF_W-1:0]   ref_ang,
   input  logic [gipm_pkg::RECIP_W-1:0]        recip,
   output logic signed [gipm_pkg::FRAC_W-1:0]  frac,
   output logic                                sat
);
   import gipm_pkg::*;

   logic signed [AW:0]      rnd;
   logic signed [NUM_W-1:0] num;
   logic [NUM_W-1:0]        mag_in, mag_ff;
   logic                    neg1_ff, neg2_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [PROD_W:0]         sum;
   logic [37:0]             q;
   logic signed [FRAC_W-1:0] frac_in, frac_ff;
   logic                    sat_in, sat_ff;

   always_comb begin
      rnd    = (AW+1)'(ang) + (AW+1)'(1 << (ANG_SH - 1));
      num    = NUM_W'(rnd >>> ANG_SH) - (NUM_W'(ref_ang) <<< ANGLE_GUARD);
      mag_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg1_ff <= num[NUM_W-1];
      prod_ff <= PROD_W'(mag_ff) * PROD_W'(recip);
      neg2_ff <= neg1_ff;
   end

   always_comb begin
      sum = (PROD_W+1)'(prod_ff) + (PROD_W+1)'(1 << (OUT_SH - 1));
      q   = 38'(sum >> OUT_SH);
      sat_in = 1'b0;
      if (!neg2_ff) begin
         if (q > FRAC_MAX_MAG) begin
            frac_in = FRAC_MAX;
            sat_in  = 1'b1;
         end else begin
            frac_in = FRAC_W'(q);
         end
      end else begin
         if (q > FRAC_MIN_MAG) begin
            frac_in = FRAC_W'(-FRAC_MIN_MAG);
            sat_in  = 1'b1;
         end else begin
            frac_in = FRAC_W'(-q);
         end
      end
   end

   always_ff @(posedge clock) begin
      frac_ff <= frac_in;
      sat_ff  <= sat_in;
   end

   assign frac = frac_ff;
   assign sat  = sat_ff;

endmodule
`default_nettype wire

[design/ground_to_image_perspective_map.sv]
// Top level of the ground-to-image map: config registers, offset stage, two
// normalize + CORDIC passes and the fraction units. Depends on gipm_pkg and submodules.
//
// channel   ports                                   handshake
// input     req_ground_x, req_ground_y              start & !busy
// result    rsp_row_fraction, rsp_column_fraction,  rsp_strobe, one cycle
//           rsp_degenerate, rsp_saturated
// config    csr_index, csr_data                     csr_write
//
// One item per cycle; each result follows its item through the offset register,
// two normalize + 30-stage CORDIC passes with a rescale register between them, and
// the scale stages of the fraction units.
// busy stays low; the pipeline never stalls and the receiver cannot stall.
// Synchronous reset clears the valid bits and loads the register defaults.
`default_nettype none
module ground_to_image_perspective_map (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [31:0]                   req_ground_x,
   input  logic signed [31:0]                   req_ground_y,
   output logic                                 rsp_strobe,
   output logic signed [gipm_pkg::FRAC_W-1:0]   rsp_row_fraction,
   output logic signed [gipm_pkg::FRAC_W-1:0]   rsp_column_fraction,
   output logic                                 rsp_degenerate,
   output logic                                 rsp_saturated,
   input  logic                                 csr_write,
   input  logic [2:0]                           csr_index,
   input  logic [31:0]                          csr_data
);
   import gipm_pkg::*;

   logic [HGT_W-1:0]        height_ff;
   logic signed [31:0]      forward_ff, lateral_ff;
   logic signed [19:0]      pitch_ff, yaw_ff;
   logic [18:0]             half_ap_ff;
   logic [RECIP_W-1:0]      recip_ff;

   logic                    accept;
   logic                    v1_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   side_type                side1;

   logic signed [CW-1:0]    n1_x, n1_y, c1_x, n2_x, n2_y, c2_x;
   logic signed [AW-1:0]    n1_z, c1_z, n2_z, c2_z;
   side_type                n1_side, c1_side, n2_side, c2_side;

   logic [SW-1:0]           lamt, ramt;
   logic signed [CW-1:0]    xr_in, xr_ff, yh_ff;
   side_type                side2_in, side2_ff;
   logic [HPROD_W-1:0]      hprod;

   logic signed [AW-1:0]    el;
   logic signed [REF_W-1:0] ref_row, ref_col;
   logic signed [FRAC_W-1:0] row_frac, col_frac;
   logic                    row_sat, col_sat;
   logic                    vf_ff [FRAC_LAT];
   logic                    df_ff [FRAC_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff  <= 31'd327680;
         forward_ff <= '0;
         lateral_ff <= '0;
         pitch_ff   <= 20'sd34314;
         yaw_ff     <= -20'sd1144;
         half_ap_ff <= 19'd17157;
         recip_ff   <= 31'd125168;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            REG_HEIGHT:  height_ff  <= csr_data[HGT_W-1:0];
            REG_FORWARD: forward_ff <= csr_data;
            REG_LATERAL: lateral_ff <= csr_data;
            REG_PITCH:   pitch_ff   <= csr_data[19:0];
            REG_YAW:     yaw_ff     <= csr_data[19:0];
            REG_HALF_AP: half_ap_ff <= csr_data[18:0];
            REG_RECIP:   recip_ff   <= csr_data[RECIP_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      dx_ff <= DIFF_W'(req_ground_x) - DIFF_W'(forward_ff);
      dy_ff <= DIFF_W'(req_ground_y) - DIFF_W'(lateral_ff);
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_comb begin
      side1.valid = v1_ff;
      side1.neg   = dx_ff[DIFF_W-1];
      side1.degen = (dx_ff == '0) && (dy_ff == '0);
      side1.shift = '0;
      side1.az    = '0;
   end

   gipm_norm u_norm1 (
      .clock(clock), .reset(reset),
      .in_x(CW'(dx_ff)), .in_y(CW'(dy_ff)), .in_side(side1),
      .out_x(n1_x), .out_y(n1_y), .out_z(n1_z), .out_side(n1_side)
   );

   gipm_cordic u_cordic1 (
      .clock(clock), .reset(reset),
      .in_x(n1_x), .in_y(n1_y), .in_z(n1_z), .in_side(n1_side),
      .out_x(c1_x), .out_z(c1_z), .out_side(c1_side)
   );

   // scale the magnitude back to a common 2^(FRAC_BITS+20) grid
   always_comb begin
      lamt = SW'(XR_SHIFT) - c1_side.shift;
      ramt = c1_side.shift - SW'(XR_SHIFT);
      if (c1_side.shift <= SW'(XR_SHIFT)) begin
         xr_in = c1_x << lamt[MSB_W-1:0];
      end else begin
         xr_in = c1_x >> ramt[MSB_W-1:0];
      end
      side2_in    = c1_side;
      side2_in.az = c1_side.degen ? '0 : c1_z;
   end

   assign hprod = HPROD_W'(height_ff) * HPROD_W'(GAIN_Q30);

   always_ff @(posedge clock) begin
      xr_ff <= xr_in;
      yh_ff <= CW'(hprod[HPROD_W-1:HPROD_SH]);
      if (reset) begin
         side2_ff <= '0;
      end else begin
         side2_ff <= side2_in;
      end
   end

   gipm_norm u_norm2 (
      .clock(clock), .reset(reset),
      .in_x(xr_ff), .in_y(yh_ff), .in_side(side2_ff),
      .out_x(n2_x), .out_y(n2_y), .out_z(n2_z), .out_side(n2_side)
   );

   gipm_cordic u_cordic2 (
      .clock(clock), .reset(reset),
      .in_x(n2_x), .in_y(n2_y), .in_z(n2_z), .in_side(n2_side),
      .out_x(c2_x), .out_z(c2_z), .out_side(c2_side)
   );

   always_comb begin
      if (c2_side.degen) begin
         el = HALF_PI_Q30;
      end else if (c2_side.neg) begin
         el = -c2_z;
      end else begin
         el = c2_z;
      end
      ref_row = REF_W'(pitch_ff) - REF_W'(half_ap_ff);
      ref_col = REF_W'(yaw_ff) - REF_W'(half_ap_ff);
   end

   gipm_frac u_frac_row (
      .clock(clock), .ang(el), .ref_ang(ref_row), .recip(recip_ff),
      .frac(row_frac), .sat(row_sat)
   );

   gipm_frac u_frac_col (
      .clock(clock), .ang(c2_side.az), .ref_ang(ref_col), .recip(recip_ff),
      .frac(col_frac), .sat(col_sat)
   );

   always_ff @(posedge clock) begin
      df_ff[0] <= c2_side.degen;
      for (int k = 1; k < FRAC_LAT; k++) begin
         df_ff[k] <= df_ff[k-1];
      end
      if (reset) begin
         for (int k = 0; k < FRAC_LAT; k++) begin
            vf_ff[k] <= 1'b0;
         end
      end else begin
         vf_ff[0] <= c2_side.valid;
         for (int k = 1; k < FRAC_LAT; k++) begin
            vf_ff[k] <= vf_ff[k-1];
         end
      end
   end

   assign rsp_strobe          = vf_ff[FRAC_LAT-1];
   assign rsp_degenerate      = df_ff[FRAC_LAT-1];
   assign rsp_row_fraction    = row_frac;
   assign rsp_column_fraction = col_frac;
   assign rsp_saturated       = row_sat || col_sat;

   a_strobe_from_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result without an item");

   a_item_gives_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("item lost in pipeline");

   a_xr_positive: assert property (@(posedge clock) disable iff (reset)
      (side2_ff.valid && !side2_ff.degen) |-> !xr_ff[CW-1])
      else $error("elevation vector in left half plane");

   a_mag_positive: assert property (@(posedge clock) disable iff (reset)
      (c2_side.valid && !c2_side.degen) |-> !c2_x[CW-1])
      else $error("negative CORDIC magnitude");

endmodule
`default_nettype wire

[verif/ground_to_image_perspective_map_tb.sv]
// Self-checking testbench for ground_to_image_perspective_map: drives ground points
// and register settings, predicts each image position in-bench, checks every result.
// Depends on gipm_pkg and the design under design/.
`timescale 1ns / 1ps
module ground_to_image_perspective_map_tb;
   import gipm_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = 80;
   localparam longint HALF_PI = 64'sd1686629713;
   localparam longint unsigned CORDIC_GAIN = 64'd1768195363;
   localparam longint ARCTAN [30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
      64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
   };

   typedef struct {
      logic signed [19:0] row;
      logic signed [19:0] col;
      logic               degen;
      logic               sat;
   } image_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_ground_x = '0;
   logic signed [31:0] req_ground_y = '0;
   logic rsp_strobe;
   logic signed [19:0] rsp_row_fraction;
   logic signed [19:0] rsp_column_fraction;
   logic rsp_degenerate;
   logic rsp_saturated;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   logic [30:0]        cam_height = 31'd327680;
   logic signed [31:0] fwd_off = '0;
   logic signed [31:0] lat_off = '0;
   logic signed [19:0] pitch = 20'sd34314;
   logic signed [19:0] yaw = -20'sd1144;
   logic [18:0]        half_ap = 19'd17157;
   logic [30:0]        recip = 31'd125168;

   image_point_type pending_points[$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int burst_left = 0;

   always #10 clock = ~clock;

   ground_to_image_perspective_map u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ground_x(req_ground_x), .req_ground_y(req_ground_y),
      .rsp_strobe(rsp_strobe), .rsp_row_fraction(rsp_row_fraction),
      .rsp_column_fraction(rsp_column_fraction), .rsp_degenerate(rsp_degenerate),
      .rsp_saturated(rsp_saturated), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   function automatic longint abs_of(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint cordic_angle(input longint y_in, input longint x_in,
                                           output longint mag, output int shift);
      longint x, y, t, xs, ys, z;
      int s;
      x = x_in;
      y = y_in;
      z = 0;
      s = 0;
      if (x == 0 && y == 0) begin
         mag = 0;
         shift = 0;
         return 0;
      end
      while ((abs_of(x) > abs_of(y) ? abs_of(x) : abs_of(y)) >= (64'sd1 << 51)) begin
         x = x >>> 1;
         y = y >>> 1;
         s--;
      end
      while ((abs_of(x) > abs_of(y) ? abs_of(x) : abs_of(y)) < (64'sd1 << 50)) begin
         x = x * 2;
         y = y * 2;
         s++;
      end
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = HALF_PI;
         end else begin
            x = -y; y = t; z = -HALF_PI;
         end
      end
      for (int i = 0; i < 30; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += ARCTAN[i];
         end else begin
            x -= ys; y += xs; z -= ARCTAN[i];
         end
      end
      mag = x;
      shift = s;
      return z;
   endfunction

   function automatic logic [19:0] scale_angle(input longint ang, input longint ref_ang,
                                               inout logic sat);
      longint num;
      longint unsigned p, q;
      logic neg;
      num = ((ang + 512) >>> 10) - ref_ang * 16;
      neg = num < 0;
      p = longint'(abs_of(num)) * longint'({33'd0, recip});
      q = (p + (64'd1 << 19)) >> 20;
      if (!neg) begin
         if (q > 64'd524287) begin
            q = 64'd524287;
            sat = 1'b1;
         end
         return q[19:0];
      end
      if (q > 64'd524288) begin
         q = 64'd524288;
         sat = 1'b1;
      end
      q = 64'd0 - q;
      return q[19:0];
   endfunction

   function automatic image_point_type project_point(input logic signed [31:0] gx,
                                                     input logic signed [31:0] gy);
      image_point_type pt;
      longint dx, dy, az, el, m, m2, yh, xr, ha;
      int s, s2;
      logic sat;
      dx = longint'(gx) - longint'(fwd_off);
      dy = longint'(gy) - longint'(lat_off);
      ha = longint'({45'd0, half_ap});
      sat = 1'b0;
      pt.degen = (dx == 0 && dy == 0);
      az = cordic_angle(dy, dx, m, s);
      if (pt.degen) begin
         az = 0;
         el = HALF_PI;
      end else begin
         yh = longint'((longint'({33'd0, cam_height}) * CORDIC_GAIN) >> 10);
         if (s <= 20) xr = longint'(longint'(m) << (20 - s));
         else xr = longint'(longint'(m) >> (s - 20));
         el = cordic_angle(yh, xr, m2, s2);
         if (dx < 0) el = -el;
      end
      pt.row = scale_angle(el, longint'(pitch) - ha, sat);
      pt.col = scale_angle(az, longint'(yaw) - ha, sat);
      pt.sat = sat;
      return pt;
   endfunction

   always @(posedge clock) begin
      if (!reset && start && !busy) pending_points.push_back(project_point(req_ground_x,
                                                                           req_ground_y));
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      image_point_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (pending_points.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = pending_points.pop_front();
            if (rsp_row_fraction !== want.row)
               report_mismatch("row_fraction", rsp_row_fraction, want.row);
            if (rsp_column_fraction !== want.col)
               report_mismatch("column_fraction", rsp_column_fraction, want.col);
            if (rsp_degenerate !== want.degen)
               report_mismatch("degenerate", rsp_degenerate, want.degen);
            if (rsp_saturated !== want.sat)
               report_mismatch("saturated", rsp_saturated, want.sat);
         end
      end
   end

   task automatic send_item(input logic signed [31:0] gx, input logic signed [31:0] gy);
      start <= 1'b1;
      req_ground_x <= gx;
      req_ground_y <= gy;
      do @(posedge clock); while (busy);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 10);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_HEIGHT:  cam_height = val[30:0];
         REG_FORWARD: fwd_off = val;
         REG_LATERAL: lat_off = val;
         REG_PITCH:   pitch = val[19:0];
         REG_YAW:     yaw = val[19:0];
         REG_HALF_AP: half_ap = val[18:0];
         REG_RECIP:   recip = val[30:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_camera(input logic [31:0] h, input logic [31:0] fo, input logic [31:0] lo,
                             input logic [31:0] p, input logic [31:0] y,
                             input logic [31:0] ha, input logic [31:0] rc);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_FORWARD, fo);
      write_reg(REG_LATERAL, lo);
      write_reg(REG_PITCH, p);
      write_reg(REG_YAW, y);
      write_reg(REG_HALF_AP, ha);
      write_reg(REG_RECIP, rc);
   endtask

   task automatic send_near(input int spread);
      logic signed [31:0] ox, oy;
      ox = $signed($urandom_range(0, 2 * spread)) - spread;
      oy = $signed($urandom_range(0, 2 * spread)) - spread;
      send_item(fwd_off + ox, lat_off + oy);
   endtask

   task automatic test_directed_points;
      send_item(fwd_off, lat_off);
      send_item(fwd_off, lat_off + 32'sd65536);
      send_item(fwd_off, lat_off - 32'sd65536);
      send_item(fwd_off + 32'sd1, lat_off);
      send_item(fwd_off - 32'sd1, lat_off);
      send_item(32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_item(32'sh80000000, 32'sh80000000);
      send_item(32'sh7FFFFFFF, 32'sh80000000);
      send_item(32'sh80000000, 32'sh7FFFFFFF);
      send_item(32'sd655360, 32'sd0);
      send_item(-32'sd655360, 32'sd131072);
      send_item(-32'sd655360, -32'sd131072);
      send_item(32'sd1310720, 32'sd65536);
      send_item(32'sd0, 32'sd0);
      send_item(32'sd3, -32'sd5);
      drain();
   endtask

   task automatic test_register_extremes;
      set_camera(32'd0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFF, 32'h80000, 32'd0, 32'd0);
      test_directed_points();
      set_camera(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000, 32'h7FFFF,
                 32'h7FFFF, 32'h7FFFFFFF);
      test_directed_points();
      set_camera(32'hFFFFFFFF, 32'd0, 32'd0, 32'hFFFFF, 32'd0, 32'd1, 32'h40000000);
      write_reg(REG_UNUSED, 32'hFFFFFFFF);
      test_directed_points();
   endtask

   task automatic test_random_settings(input int phases, input int per_phase);
      logic [18:0] ha;
      for (int ph = 0; ph < phases; ph++) begin
         ha = $urandom_range(2000, 60000);
         set_camera($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 24),
                    $signed($urandom_range(0, 1 << 24)) - (1 << 23),
                    $signed($urandom_range(0, 1 << 24)) - (1 << 23),
                    $urandom, $urandom, ha,
                    ph % 3 == 2 ? $urandom : (32'h80000000 / ha));
         for (int n = 0; n < per_phase; n++) begin
            case ($urandom_range(0, 9))
               0, 1:    send_item($urandom, $urandom);
               2:       send_item(fwd_off, lat_off);
               3:       send_item(fwd_off, $urandom);
               4:       send_near(16);
               default: send_near(1 << 22);
            endcase
         end
         drain();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_points();
      test_register_extremes();
      test_random_settings(10, 50);
      set_camera(32'd327680, 32'd0, 32'd0, 32'd34314, -32'sd1144, 32'd17157, 32'd125168);
      test_directed_points();
      $display("covered %0d ground points with %0d results over default, extreme and",
               items_sent, results_seen);
      $display("random camera settings, including footprint and saturation cases");
      if (errors == 0)
         $display("** ground_to_image_perspective_map: PASSED **");
      else
         $display("** ground_to_image_perspective_map: FAILED **");
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout waiting for results");
      $display("** ground_to_image_perspective_map: FAILED **");
      $finish;
   end

endmodule
